[rtl/core/pcd_pkg.sv]
// Package for the packed callsign decoder: types, range limits, divider constants, char tables.
package pcd_pkg;

    localparam int unsigned CALL_W    = 28;
    localparam int unsigned DIG_W     = 6;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned MAX_CHARS = 7;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned DIV_CNT   = 5;
    localparam int unsigned RCP_W     = 25;
    localparam int unsigned FRAC_W    = 28;

    localparam logic [CALL_W-1:0] CQ_NUM_BASE   = 28'd3;
    localparam logic [CALL_W-1:0] CQ_NUM_LAST   = 28'd1002;
    localparam logic [CALL_W-1:0] CQ_ALPHA_BASE = CQ_NUM_LAST + 28'd1;
    localparam logic [CALL_W-1:0] CQ_ALPHA_LAST = 28'd532443;
    localparam logic [CALL_W-1:0] TOKEN_LIMIT   = 28'd2063592;
    localparam logic [CALL_W-1:0] HASH22_SPAN   = 28'd4194304;
    localparam logic [CALL_W-1:0] SIX_BASE      = TOKEN_LIMIT + HASH22_SPAN;

    localparam logic [DIG_W-1:0] DIV_LETTER = 6'd27;
    localparam logic [DIG_W-1:0] DIV_DIGIT  = 6'd10;
    localparam logic [DIG_W-1:0] DIV_ALNUM  = 6'd36;
    localparam logic [DIG_W-1:0] DIV_FULL   = 6'd37;

    // floor(2^FRAC_W / d): quotient estimate is low by at most one
    localparam logic [RCP_W-1:0] RCP_LETTER = RCP_W'((64'd1 << FRAC_W) / DIV_LETTER);
    localparam logic [RCP_W-1:0] RCP_DIGIT  = RCP_W'((64'd1 << FRAC_W) / DIV_DIGIT);
    localparam logic [RCP_W-1:0] RCP_ALNUM  = RCP_W'((64'd1 << FRAC_W) / DIV_ALNUM);

    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    typedef enum logic [2:0] {
        KIND_DE,
        KIND_QRZ,
        KIND_CQ,
        KIND_NUM,
        KIND_ALPHA,
        KIND_TOKEN,
        KIND_HASH,
        KIND_SIX
    } kind_t;

    typedef logic [MAX_CHARS-1:0][CHAR_W-1:0] text_t;

    typedef struct packed {
        kind_t                          kind;
        logic [CALL_W-1:0]              val;
        logic [DIV_CNT-1:0][DIG_W-1:0]  digs;
    } item_t;

    typedef struct packed {
        item_t             item;
        logic [RCP_W-1:0]  q_est;
    } prod_t;

    function automatic logic [DIG_W-1:0] div_sel(input kind_t kind, input int unsigned pos);
        logic [DIG_W-1:0] d;
        if (kind == KIND_ALPHA) begin
            d = DIV_LETTER;
        end else if (kind == KIND_NUM && pos < 2) begin
            d = DIV_DIGIT;
        end else if (pos < 3) begin
            d = DIV_LETTER;
        end else if (pos == 3) begin
            d = DIV_DIGIT;
        end else begin
            d = DIV_ALNUM;
        end
        return d;
    endfunction

    function automatic logic [RCP_W-1:0] recip_sel(input logic [DIG_W-1:0] d);
        logic [RCP_W-1:0] r;
        unique case (d)
            DIV_DIGIT: r = RCP_DIGIT;
            DIV_ALNUM: r = RCP_ALNUM;
            default:   r = RCP_LETTER;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] letter_char(input logic [DIG_W-1:0] idx);
        return (idx == '0) ? CH_SPACE : CHAR_W'({1'b0, idx}) + 7'h40;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] idx);
        return CHAR_W'({1'b0, idx}) + 7'h30;
    endfunction

    function automatic logic [CHAR_W-1:0] alnum_char(input logic [DIG_W-1:0] idx);
        return (idx < 6'd10) ? CHAR_W'({1'b0, idx}) + 7'h30 : CHAR_W'({1'b0, idx}) + 7'h37;
    endfunction

    function automatic logic [CHAR_W-1:0] full_char(input logic [DIG_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        if (idx == '0) begin
            c = CH_SPACE;
        end else if (idx < 6'd11) begin
            c = CHAR_W'({1'b0, idx}) + 7'h2F;
        end else begin
            c = CHAR_W'({1'b0, idx}) + 7'h36;
        end
        return c;
    endfunction

    // first character of the string lands in entry 0
    function automatic text_t text_of(input logic [8*MAX_CHARS-1:0] s);
        text_t t;
        for (int i = 0; i < MAX_CHARS; i++) begin
            t[i] = s[8*(MAX_CHARS-1-i) +: CHAR_W];
        end
        return t;
    endfunction

endpackage

[rtl/core/packed_callsign_decode.sv]
// Packed callsign decoder top level: range classify, divider pipeline, formatter, char serializer.
//
//  channel | ports                        | dir | beat
//  --------+------------------------------+-----+--------------------------------
//  s_      | s_valid s_ready s_packed_call| in  | one 28-bit packed callsign
//  m_      | m_valid m_ready m_text_char  | out | one ASCII char, m_last on final
//          | m_last                       |     |
//
//  Path from input beat to first char: input reg, 5 x multiply/correct, format,
//  serializer.
//  The serializer register that drives m_ and moves one char per beat sets the callsign rate;
//  it loads the next text only when it is empty or its last char is being taken.
//  Pipeline stages advance together on a shared enable; a loaded format stage waiting on a
//  busy serializer holds all of them.
//  Reset (aresetn low, synchronous) clears the valid bits and the char count.
module packed_callsign_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pcd_pkg::CALL_W-1:0]    s_packed_call,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcd_pkg::CHAR_W-1:0]    m_text_char,
    output logic                          m_last
);

    localparam int unsigned MUL_W = pcd_pkg::CALL_W + pcd_pkg::RCP_W;

    logic                           en;
    logic                           ser_free;
    pcd_pkg::item_t                 in_item;

    logic                           st_valid [pcd_pkg::DIV_CNT+1];
    pcd_pkg::item_t                 st_item  [pcd_pkg::DIV_CNT+1];

    logic                           in_valid_reg;
    pcd_pkg::item_t                 in_reg;

    pcd_pkg::text_t                 fmt_next;
    logic [pcd_pkg::LEN_W-1:0]      fmt_len_next;
    logic                           fmt_valid_reg;
    pcd_pkg::text_t                 fmt_reg;
    logic [pcd_pkg::LEN_W-1:0]      fmt_len_reg;

    pcd_pkg::text_t                 ser_chars_reg;
    pcd_pkg::text_t                 ser_chars_next;
    logic [pcd_pkg::LEN_W-1:0]      ser_cnt_reg;
    logic [pcd_pkg::LEN_W-1:0]      ser_cnt_next;

    // classify
    always_comb begin
        in_item.digs = '0;
        in_item.val  = s_packed_call;
        priority if (s_packed_call == pcd_pkg::CALL_W'(0)) begin
            in_item.kind = pcd_pkg::KIND_DE;
        end else if (s_packed_call == pcd_pkg::CALL_W'(1)) begin
            in_item.kind = pcd_pkg::KIND_QRZ;
        end else if (s_packed_call == pcd_pkg::CALL_W'(2)) begin
            in_item.kind = pcd_pkg::KIND_CQ;
        end else if (s_packed_call <= pcd_pkg::CQ_NUM_LAST) begin
            in_item.kind = pcd_pkg::KIND_NUM;
            in_item.val  = s_packed_call - pcd_pkg::CQ_NUM_BASE;
        end else if (s_packed_call <= pcd_pkg::CQ_ALPHA_LAST) begin
            in_item.kind = pcd_pkg::KIND_ALPHA;
            in_item.val  = s_packed_call - pcd_pkg::CQ_ALPHA_BASE;
        end else if (s_packed_call < pcd_pkg::TOKEN_LIMIT) begin
            in_item.kind = pcd_pkg::KIND_TOKEN;
        end else if (s_packed_call < pcd_pkg::SIX_BASE) begin
            in_item.kind = pcd_pkg::KIND_HASH;
        end else begin
            in_item.kind = pcd_pkg::KIND_SIX;
            in_item.val  = s_packed_call - pcd_pkg::SIX_BASE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= in_item;
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_item[0]  = in_reg;

    // one constant divide per pair of stages: reciprocal multiply, then correct by one
    for (genvar g = 0; g < pcd_pkg::DIV_CNT; g++) begin : g_div
        logic [pcd_pkg::DIG_W-1:0]   mul_div;
        logic [MUL_W-1:0]            mul_prod;
        pcd_pkg::prod_t              mul_next;
        logic                        mul_valid_reg;
        pcd_pkg::prod_t              mul_reg;

        logic [pcd_pkg::DIG_W-1:0]   cor_div;
        logic [pcd_pkg::CALL_W-1:0]  cor_qd;
        logic [pcd_pkg::CALL_W-1:0]  cor_rem;
        pcd_pkg::item_t              cor_next;
        logic                        cor_valid_reg;
        pcd_pkg::item_t              cor_reg;

        always_comb begin
            mul_div        = pcd_pkg::div_sel(st_item[g].kind, g);
            mul_prod       = MUL_W'(st_item[g].val) * MUL_W'(pcd_pkg::recip_sel(mul_div));
            mul_next.item  = st_item[g];
            mul_next.q_est = mul_prod[pcd_pkg::FRAC_W +: pcd_pkg::RCP_W];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mul_valid_reg <= 1'b0;
            end else if (en) begin
                mul_valid_reg <= st_valid[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mul_reg <= mul_next;
            end
        end

        always_comb begin
            cor_div  = pcd_pkg::div_sel(mul_reg.item.kind, g);
            cor_qd   = pcd_pkg::CALL_W'(mul_reg.q_est) * pcd_pkg::CALL_W'(cor_div);
            cor_rem  = mul_reg.item.val - cor_qd;
            cor_next = mul_reg.item;
            if (cor_rem >= pcd_pkg::CALL_W'(cor_div)) begin
                cor_next.val     = pcd_pkg::CALL_W'(mul_reg.q_est) + pcd_pkg::CALL_W'(1);
                cor_next.digs[g] = pcd_pkg::DIG_W'(cor_rem - pcd_pkg::CALL_W'(cor_div));
            end else begin
                cor_next.val     = pcd_pkg::CALL_W'(mul_reg.q_est);
                cor_next.digs[g] = cor_rem[pcd_pkg::DIG_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cor_valid_reg <= 1'b0;
            end else if (en) begin
                cor_valid_reg <= mul_valid_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cor_reg <= cor_next;
            end
        end

        assign st_valid[g+1] = cor_valid_reg;
        assign st_item[g+1]  = cor_reg;
    end

    // format
    always_comb begin
        pcd_pkg::item_t it;
        it           = st_item[pcd_pkg::DIV_CNT];
        fmt_next     = pcd_pkg::text_of("CQ     ");
        fmt_len_next = pcd_pkg::LEN_W'(2);
        unique case (it.kind)
            pcd_pkg::KIND_DE: begin
                fmt_next     = pcd_pkg::text_of("DE     ");
                fmt_len_next = pcd_pkg::LEN_W'(2);
            end
            pcd_pkg::KIND_QRZ: begin
                fmt_next     = pcd_pkg::text_of("QRZ    ");
                fmt_len_next = pcd_pkg::LEN_W'(3);
            end
            pcd_pkg::KIND_CQ: begin
                fmt_next     = pcd_pkg::text_of("CQ     ");
                fmt_len_next = pcd_pkg::LEN_W'(2);
            end
            pcd_pkg::KIND_NUM: begin
                if (it.digs[2] != '0) begin
                    fmt_next[3]  = pcd_pkg::digit_char(it.digs[2]);
                    fmt_next[4]  = pcd_pkg::digit_char(it.digs[1]);
                    fmt_next[5]  = pcd_pkg::digit_char(it.digs[0]);
                    fmt_len_next = pcd_pkg::LEN_W'(6);
                end else if (it.digs[1] != '0) begin
                    fmt_next[3]  = pcd_pkg::digit_char(it.digs[1]);
                    fmt_next[4]  = pcd_pkg::digit_char(it.digs[0]);
                    fmt_len_next = pcd_pkg::LEN_W'(5);
                end else begin
                    fmt_next[3]  = pcd_pkg::digit_char(it.digs[0]);
                    fmt_len_next = pcd_pkg::LEN_W'(4);
                end
            end
            pcd_pkg::KIND_ALPHA: begin
                fmt_next[3]  = pcd_pkg::letter_char(it.digs[3]);
                fmt_next[4]  = pcd_pkg::letter_char(it.digs[2]);
                fmt_next[5]  = pcd_pkg::letter_char(it.digs[1]);
                fmt_next[6]  = pcd_pkg::letter_char(it.digs[0]);
                fmt_len_next = pcd_pkg::LEN_W'(7);
            end
            pcd_pkg::KIND_TOKEN: begin
                fmt_next     = pcd_pkg::text_of("<TOKEN>");
                fmt_len_next = pcd_pkg::LEN_W'(7);
            end
            pcd_pkg::KIND_HASH: begin
                fmt_next     = pcd_pkg::text_of("<...22>");
                fmt_len_next = pcd_pkg::LEN_W'(7);
            end
            pcd_pkg::KIND_SIX: begin
                fmt_next[0]  = pcd_pkg::full_char(it.val[pcd_pkg::DIG_W-1:0]);
                fmt_next[1]  = pcd_pkg::alnum_char(it.digs[4]);
                fmt_next[2]  = pcd_pkg::digit_char(it.digs[3]);
                fmt_next[3]  = pcd_pkg::letter_char(it.digs[2]);
                fmt_next[4]  = pcd_pkg::letter_char(it.digs[1]);
                fmt_next[5]  = pcd_pkg::letter_char(it.digs[0]);
                fmt_len_next = pcd_pkg::LEN_W'(6);
            end
            default: begin
                fmt_next     = pcd_pkg::text_of("CQ     ");
                fmt_len_next = pcd_pkg::LEN_W'(2);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_valid_reg <= 1'b0;
        end else if (en) begin
            fmt_valid_reg <= st_valid[pcd_pkg::DIV_CNT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fmt_reg     <= fmt_next;
            fmt_len_reg <= fmt_len_next;
        end
    end

    // serializer: entry 0 drives the port, shifts down per beat
    assign ser_free = (ser_cnt_reg == '0) || (ser_cnt_reg == pcd_pkg::LEN_W'(1) && m_ready);
    assign en       = !fmt_valid_reg || ser_free;
    assign s_ready  = en;

    always_comb begin
        ser_chars_next = ser_chars_reg;
        ser_cnt_next   = ser_cnt_reg;
        if (fmt_valid_reg && ser_free) begin
            ser_chars_next = fmt_reg;
            ser_cnt_next   = fmt_len_reg;
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < pcd_pkg::MAX_CHARS - 1; i++) begin
                ser_chars_next[i] = ser_chars_reg[i+1];
            end
            ser_chars_next[pcd_pkg::MAX_CHARS-1] = pcd_pkg::CH_SPACE;
            ser_cnt_next = ser_cnt_reg - pcd_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_cnt_reg <= '0;
        end else begin
            ser_cnt_reg <= ser_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ser_chars_reg <= ser_chars_next;
    end

    assign m_valid     = (ser_cnt_reg != '0);
    assign m_text_char = ser_chars_reg[0];
    assign m_last      = (ser_cnt_reg == pcd_pkg::LEN_W'(1));

    a_fmt_len: assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_valid_reg |-> fmt_len_reg >= pcd_pkg::LEN_W'(2))
        else $error("formatter produced a text shorter than two chars");

    a_more_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("text ended without a last beat");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> fmt_valid_reg && m_valid)
        else $error("pipeline stalled with no pending output");

    a_six_top: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid[pcd_pkg::DIV_CNT] && st_item[pcd_pkg::DIV_CNT].kind == pcd_pkg::KIND_SIX
        |-> st_item[pcd_pkg::DIV_CNT].val < pcd_pkg::CALL_W'(pcd_pkg::DIV_FULL))
        else $error("leading radix-37 index out of range");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for packed_callsign_decode: directed and random callsigns, char checks.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned NUM_LAST    = 1002;
    localparam int unsigned ALPHA_LAST  = 532443;
    localparam int unsigned TOKEN_END   = 2063592;
    localparam int unsigned HASH_SPAN   = 4194304;
    localparam int unsigned SIX_START   = TOKEN_END + HASH_SPAN;
    localparam int unsigned CALL_MAX    = (1 << pcd_pkg::CALL_W) - 1;
    localparam int unsigned RAND_ITEMS  = 120;
    localparam int unsigned DRAIN_CYC   = 40;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [pcd_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } char_beat_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [pcd_pkg::CALL_W-1:0] s_packed_call = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [pcd_pkg::CHAR_W-1:0] m_text_char;
    logic                       m_last;

    logic [pcd_pkg::CALL_W-1:0] pending_calls[$];
    char_beat_t                 expected_chars[$];
    int unsigned                send_idle_pct = 0;
    int unsigned                recv_stall_pct = 0;
    int unsigned                mismatches = 0;

    string full_set   = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string alnum_set  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string digit_set  = "0123456789";
    string letter_set = " ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    packed_callsign_decode u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packed_call (s_packed_call),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_text_char   (m_text_char),
        .m_last        (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void predict_callsign(input logic [pcd_pkg::CALL_W-1:0] call);
        int unsigned x;
        int unsigned v;
        string       txt;
        byte         b;
        char_beat_t  beat;
        x = 32'(call);
        if (x == 0) begin
            txt = "DE";
        end else if (x == 1) begin
            txt = "QRZ";
        end else if (x == 2) begin
            txt = "CQ";
        end else if (x <= NUM_LAST) begin
            txt = $sformatf("CQ %0d", x - 3);
        end else if (x <= ALPHA_LAST) begin
            v = x - (NUM_LAST + 1);
            txt = $sformatf("CQ %c%c%c%c", letter_set[(v / 19683) % 27],
                            letter_set[(v / 729) % 27], letter_set[(v / 27) % 27],
                            letter_set[v % 27]);
        end else if (x < TOKEN_END) begin
            txt = "<TOKEN>";
        end else if (x < SIX_START) begin
            txt = "<...22>";
        end else begin
            v = x - SIX_START;
            txt = $sformatf("%c%c%c%c%c%c",
                            full_set[(v / (27 * 27 * 27 * 10 * 36)) % 37],
                            alnum_set[(v / (27 * 27 * 27 * 10)) % 36],
                            digit_set[(v / (27 * 27 * 27)) % 10],
                            letter_set[(v / 729) % 27], letter_set[(v / 27) % 27],
                            letter_set[v % 27]);
        end
        for (int i = 0; i < txt.len(); i++) begin
            b = txt[i];
            beat.ch = b[pcd_pkg::CHAR_W-1:0];
            beat.last = (i == txt.len() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic logic [pcd_pkg::CALL_W-1:0] random_call();
        int unsigned r;
        logic [pcd_pkg::CALL_W-1:0] c;
        r = $urandom_range(99);
        if (r < 5) begin
            c = pcd_pkg::CALL_W'($urandom_range(NUM_LAST, 0));
        end else if (r < 25) begin
            c = pcd_pkg::CALL_W'($urandom_range(ALPHA_LAST, NUM_LAST + 1));
        end else if (r < 33) begin
            c = pcd_pkg::CALL_W'($urandom_range(TOKEN_END - 1, ALPHA_LAST + 1));
        end else if (r < 41) begin
            c = pcd_pkg::CALL_W'($urandom_range(SIX_START - 1, TOKEN_END));
        end else if (r < 51) begin
            c = pcd_pkg::CALL_W'($urandom());
        end else begin
            c = pcd_pkg::CALL_W'($urandom_range(CALL_MAX, SIX_START));
        end
        return c;
    endfunction

    // sender: next beat only once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_callsign(s_packed_call);
            end
            if (!s_valid || s_ready) begin
                if (pending_calls.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_packed_call <= pending_calls.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        char_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected char beat: char=%h last=%b", m_text_char, m_last);
                end
                mismatches++;
            end else begin
                exp_beat = expected_chars.pop_front();
                if (m_text_char !== exp_beat.ch || m_last !== exp_beat.last) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("char mismatch: expected char=%h last=%b, got char=%h last=%b",
                                 exp_beat.ch, exp_beat.last, m_text_char, m_last);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned directed[$];
        int unsigned idle_mode[4][2];
        idle_mode = '{'{0, 0}, '{79, 0}, '{0, 79}, '{24, 24}};
        directed = '{0, 1, 2, 3, 4, 12, 13, 102, 103, NUM_LAST, NUM_LAST + 1, NUM_LAST + 2,
                     NUM_LAST + 27, ALPHA_LAST, ALPHA_LAST + 1, TOKEN_END - 1, TOKEN_END,
                     SIX_START - 1, SIX_START, SIX_START + 1, SIX_START + 27 * 27 * 27 - 1,
                     CALL_MAX, 32'h5555555, 32'hAAAAAAA};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_mode[p][0];
            recv_stall_pct = idle_mode[p][1];
            if (p == 0) begin
                foreach (directed[i]) pending_calls.push_back(pcd_pkg::CALL_W'(directed[i]));
            end
            for (int i = 0; i < RAND_ITEMS; i++) begin
                pending_calls.push_back(random_call());
            end
            while (pending_calls.size() > 0) @(posedge aclk);
        end
        while (s_valid) @(posedge aclk);
        while (expected_chars.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("** packed_callsign_decode: PASSED **");
        end else begin
            $display("** packed_callsign_decode: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("** packed_callsign_decode: FAILED **");
        $finish;
    end

endmodule

[sim.f]
rtl/core/pcd_pkg.sv
rtl/core/packed_callsign_decode.sv
dv/tb_top.sv
